// ===== sv/csb_pkg.sv =====
// Shared types and codes for the counting semaphore bank.
// No dependencies; used by the top level and the checker.
package csb_pkg;

  typedef enum logic [2:0] {
    MODE_OPEN  = 3'd0,
    MODE_CLOSE = 3'd1,
    MODE_UP    = 3'd2,
    MODE_DOWN  = 3'd3,
    MODE_FIND  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ERR   = 2'd1,
    STAT_BLOCK = 2'd2,
    STAT_OVF   = 2'd3
  } stat_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  localparam int IN_INDEX_W = 6;
  localparam int IN_COUNT_W = 16;
  localparam int FREE_IDX_W = 5;

endpackage

// ===== sv/counting_semaphore_bank_unit.sv =====
// Counting semaphore bank: request decode, active flags and read-modify-write
// sequencer. Depends on csb_pkg and csb_count_ram.
//
// Usage: a request beat (mode, sem_index, initial_count) enters on in_valid
// while in_stall is low. Each request gives exactly one result beat (status,
// wake, free_found, free_index) on out_valid, held until out_stall is low.
// Counts live in a synchronous RAM with a registered read port: the count
// is read at the edge that takes the request; in the execute state, once the
// output register is free, the result is computed, the count written back and
// the output register loaded. The block holds one request at a time, so it
// takes no new request until the current one has loaded its result.
// Active flags sit in flip-flops so that find free sees all entries at once.
// Reset clears the active flags, the sequencer and the output valid; counts
// are only used on active entries; an open of an inactive entry writes it first.
// When the receiver stalls, the result waits in the output register; one
// further request can be taken and waits with its result until the register
// drains, keeping in_stall high meanwhile.
module counting_semaphore_bank_unit #(
  parameter int NUM_SEMS    = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          mode,
  input  logic [csb_pkg::IN_INDEX_W-1:0]      sem_index,
  input  logic [csb_pkg::IN_COUNT_W-1:0]      initial_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic                                wake,
  output logic                                free_found,
  output logic [csb_pkg::FREE_IDX_W-1:0]      free_index
);

  localparam int AW    = $clog2(NUM_SEMS);
  localparam int CMP_W = (COUNT_WIDTH > csb_pkg::IN_COUNT_W) ? COUNT_WIDTH
                                                             : csb_pkg::IN_COUNT_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [csb_pkg::IN_INDEX_W:0] NUM_SEMS_EXT =
    (csb_pkg::IN_INDEX_W+1)'(NUM_SEMS);

  csb_pkg::fsm_t state, state_next;

  logic [2:0]                         mode_q;
  logic [csb_pkg::IN_INDEX_W-1:0]     idx_q;
  logic [csb_pkg::IN_COUNT_W-1:0]     init_q;
  logic [NUM_SEMS-1:0]                active, active_next;
  logic [COUNT_WIDTH-1:0]             cnt_rd;
  logic                               wr_en;
  logic [COUNT_WIDTH-1:0]             wr_data;

  logic                               in_take;
  logic                               done;
  logic                               idx_ok;
  logic [AW-1:0]                      idx_a;
  logic                               cur_active;
  logic [COUNT_WIDTH-1:0]             init_sat;
  logic [CMP_W-1:0]                   init_ext;
  logic [NUM_SEMS-1:0]                free_vec, free_low;
  logic [csb_pkg::FREE_IDX_W-1:0]     free_enc;

  csb_pkg::stat_t                     res_stat;
  logic                               res_wake, res_found;
  logic [csb_pkg::FREE_IDX_W-1:0]     res_index;

  assign in_take = in_valid && !in_stall;
  assign done    = (state == csb_pkg::FSM_EXEC) && (!out_valid || !out_stall);
  assign idx_ok  = {1'b0, idx_q} < NUM_SEMS_EXT;
  assign idx_a   = idx_q[AW-1:0];
  assign cur_active = idx_ok ? active[idx_a] : 1'b0;

  assign init_ext = CMP_W'(init_q);
  assign init_sat = (init_ext > CMP_W'(COUNT_MAX)) ? COUNT_MAX
                                                   : init_ext[COUNT_WIDTH-1:0];

  // Lowest inactive entry: isolate the lowest set bit, then encode it.
  assign free_vec = ~active;
  assign free_low = free_vec & (~free_vec + NUM_SEMS'(1));

  always_comb begin
    free_enc = '0;
    for (int i = 0; i < NUM_SEMS; i++) begin
      if (free_low[i]) begin
        free_enc = free_enc | csb_pkg::FREE_IDX_W'(i);
      end
    end
  end

  csb_count_ram #(
    .DEPTH (NUM_SEMS),
    .WIDTH (COUNT_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_take),
    .rd_addr (sem_index[AW-1:0]),
    .rd_data (cnt_rd),
    .wr_en   (wr_en),
    .wr_addr (idx_a),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_q <= mode;
      idx_q  <= sem_index;
      init_q <= initial_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csb_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      csb_pkg::FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = csb_pkg::FSM_EXEC;
        end
      end
      csb_pkg::FSM_EXEC: begin
        if (done) begin
          state_next = csb_pkg::FSM_IDLE;
        end
      end
      default: state_next = csb_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    res_stat    = csb_pkg::STAT_OK;
    res_wake    = 1'b0;
    res_found   = 1'b0;
    res_index   = '0;
    wr_en       = 1'b0;
    wr_data     = cnt_rd;
    active_next = active;
    if (mode_q == csb_pkg::MODE_FIND) begin
      res_found = |free_vec;
      res_index = free_enc;
    end else if (!idx_ok) begin
      res_stat = csb_pkg::STAT_ERR;
    end else begin
      case (mode_q)
        csb_pkg::MODE_OPEN: begin
          if (!cur_active) begin
            active_next[idx_a] = 1'b1;
            wr_en   = 1'b1;
            wr_data = init_sat;
          end
        end
        csb_pkg::MODE_CLOSE: begin
          active_next[idx_a] = 1'b0;
        end
        csb_pkg::MODE_UP: begin
          if (!cur_active) begin
            res_stat = csb_pkg::STAT_ERR;
          end else if (cnt_rd == COUNT_MAX) begin
            res_stat = csb_pkg::STAT_OVF;
          end else begin
            res_wake = (cnt_rd == '0);
            wr_en    = 1'b1;
            wr_data  = cnt_rd + COUNT_WIDTH'(1);
          end
        end
        csb_pkg::MODE_DOWN: begin
          if (!cur_active) begin
            res_stat = csb_pkg::STAT_ERR;
          end else if (cnt_rd == '0) begin
            res_stat = csb_pkg::STAT_BLOCK;
          end else begin
            wr_en   = 1'b1;
            wr_data = cnt_rd - COUNT_WIDTH'(1);
          end
        end
        default: res_stat = csb_pkg::STAT_ERR;
      endcase
    end
    // Commit nothing until the result can be loaded.
    if (!done) begin
      wr_en       = 1'b0;
      active_next = active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status     <= res_stat;
      wake       <= res_wake;
      free_found <= res_found;
      free_index <= res_index;
    end
  end

endmodule

// ===== sv/csb_count_ram.sv =====
// Count storage for the semaphore bank: one write port, one registered read port.
// Depends on nothing; instantiated by counting_semaphore_bank_unit.
module csb_count_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/csb_checker.sv =====
// Port-level checks for the counting semaphore bank, bound to the top level.
// Depends on csb_pkg and counting_semaphore_bank_unit.
module csb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic       wake,
  input logic       free_found
);

  // One request in flight: a taken beat closes the input for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // Wake and find free only come with an ok status and never together.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (wake || free_found)) |->
      (status == csb_pkg::STAT_OK && !(wake && free_found)))
    else $error("wake or free_found with bad status");

  // A result beat appears only after a request was taken.
  assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(in_stall))
    else $error("result beat without a request in progress");

  // A stalled result beat holds its valid, status and wake.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(wake)))
    else $error("stalled result beat changed");

endmodule

bind counting_semaphore_bank_unit csb_checker u_csb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .wake       (wake),
  .free_found (free_found)
);
